// File: src/lmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_pkg: shared types and constants for the letter multiset checker
// Letter histogram sizes, request codes and the histogram control structs.
// ----------------------------------------------------------------------------
package lmc_pkg;

   localparam int NUM_LETTERS  = 26;
   localparam int LETTER_W     = 5;
   localparam int COUNT_W      = 6;
   localparam int ADDR_W       = $clog2(NUM_LETTERS);
   localparam int TALLY_W      = $clog2(NUM_LETTERS + 1);
   localparam int MAX_POOL_DEF = 32;
   localparam int RSP_DEPTH    = 3;
   localparam int RSP_PTR_W    = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W    = $clog2(RSP_DEPTH + 1);

   // request kinds carried on req_type
   localparam logic REQ_POOL = 1'b0;
   localparam logic REQ_WORD = 1'b1;

   // read request issued when a letter is accepted
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
   } hist_rd_type;

   // write back of one histogram entry
   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [COUNT_W-1:0] data;
   } hist_wr_type;

   // per-histogram control from the update stage
   typedef struct packed {
      logic        clr;
      hist_wr_type wr;
   } hist_ctl_type;

endpackage

// File: src/lmc_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_hist: one letter histogram
// Synchronous memory with registered read, per-entry valid bits for an
// instant clear, and forwarding of the previous cycle's write back.
// ----------------------------------------------------------------------------
module lmc_hist (
   input  logic                         clock,
   input  logic                         reset,
   input  lmc_pkg::hist_rd_type         rd,
   input  lmc_pkg::hist_ctl_type        ctl,
   output logic [lmc_pkg::COUNT_W-1:0]  old_count
);
   import lmc_pkg::*;

   logic [COUNT_W-1:0]     mem [NUM_LETTERS];
   logic [COUNT_W-1:0]     q_ff;
   logic [ADDR_W-1:0]      raddr_ff;
   logic [NUM_LETTERS-1:0] vld_ff;
   logic [NUM_LETTERS-1:0] vld_in;
   hist_wr_type            lw_ff;
   logic                   in_range;

   // write back and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr.en) begin
         mem[ctl.wr.addr] <= ctl.wr.data;
      end
      if (rd.rd_en) begin
         q_ff <= mem[rd.addr];
      end
      raddr_ff <= rd.addr;
   end

   // clear all entries at once, then mark the written entry
   always_comb begin
      vld_in = vld_ff;
      if (ctl.clr) begin
         vld_in = '0;
      end
      if (ctl.wr.en) begin
         vld_in[ctl.wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         lw_ff.en <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         lw_ff.en <= ctl.wr.en;
      end
      lw_ff.addr <= ctl.wr.addr;
      lw_ff.data <= ctl.wr.data;
   end

   // resolve the count seen by the letter now in the update stage
   assign in_range = (raddr_ff < ADDR_W'(NUM_LETTERS));

   always_comb begin
      old_count = '0;
      if (in_range) begin
         if (vld_ff[raddr_ff]) begin
            if (lw_ff.en && (lw_ff.addr == raddr_ff)) begin
               old_count = lw_ff.data;
            end else begin
               old_count = q_ff;
            end
         end
      end
   end

endmodule

// File: src/lmc_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_update: read-modify-write stage
// Bumps one histogram entry per letter and keeps running tallies (letters
// over supply, nonzero word letters, fit flag) so the answer is ready at once.
// ----------------------------------------------------------------------------
module lmc_update #(
   parameter int MAX_POOL = lmc_pkg::MAX_POOL_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          req_type,
   input  logic [lmc_pkg::LETTER_W-1:0]  req_letter,
   input  logic                          req_first,
   input  logic                          req_last,
   input  logic [lmc_pkg::COUNT_W-1:0]   pool_old,
   input  logic [lmc_pkg::COUNT_W-1:0]   word_old,
   output lmc_pkg::hist_ctl_type         pool_ctl,
   output lmc_pkg::hist_ctl_type         word_ctl,
   output logic                          push,
   output logic                          push_possible
);
   import lmc_pkg::*;

   localparam logic [COUNT_W-1:0] CAP = COUNT_W'(MAX_POOL);

   logic                s1_vld_ff;
   logic                s1_type_ff;
   logic [LETTER_W-1:0] s1_code_ff;
   logic                s1_first_ff;
   logic                s1_last_ff;

   logic [TALLY_W-1:0]  excess_ff, excess_in;
   logic [TALLY_W-1:0]  nz_ff, nz_in;
   logic                fits_ff, fits_in;

   logic                in_range;
   logic [ADDR_W-1:0]   addr;
   logic [COUNT_W-1:0]  p_old, p_new;
   logic [COUNT_W-1:0]  w_old, w_new;

   // register the accepted letter while its reads return
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
      s1_type_ff  <= req_type;
      s1_code_ff  <= req_letter;
      s1_first_ff <= req_first;
      s1_last_ff  <= req_last;
   end

   assign in_range = (s1_code_ff < LETTER_W'(NUM_LETTERS));
   assign addr     = s1_code_ff[ADDR_W-1:0];

   // modify the entry and the tallies
   always_comb begin
      excess_in = excess_ff;
      nz_in     = nz_ff;
      fits_in   = fits_ff;
      pool_ctl  = '0;
      word_ctl  = '0;
      p_old     = pool_old;
      p_new     = pool_old;
      w_old     = word_old;
      w_new     = word_old;
      if (s1_vld_ff) begin
         case (s1_type_ff)
            REQ_POOL: begin
               if (s1_first_ff) begin
                  p_old        = '0;
                  excess_in    = nz_ff;
                  pool_ctl.clr = 1'b1;
               end
               p_new = (p_old < CAP) ? p_old + COUNT_W'(1) : p_old;
               if (in_range) begin
                  if ((word_old > p_old) && !(word_old > p_new)) begin
                     excess_in = excess_in - TALLY_W'(1);
                  end
                  pool_ctl.wr.en   = 1'b1;
                  pool_ctl.wr.addr = addr;
                  pool_ctl.wr.data = p_new;
               end
            end
            REQ_WORD: begin
               if (s1_first_ff) begin
                  w_old        = '0;
                  excess_in    = '0;
                  nz_in        = '0;
                  fits_in      = 1'b1;
                  word_ctl.clr = 1'b1;
               end
               if (in_range) begin
                  if (w_old < CAP) begin
                     w_new = w_old + COUNT_W'(1);
                     if (w_old == '0) begin
                        nz_in = nz_in + TALLY_W'(1);
                     end
                     if (!(w_old > pool_old) && (w_new > pool_old)) begin
                        excess_in = excess_in + TALLY_W'(1);
                     end
                     word_ctl.wr.en   = 1'b1;
                     word_ctl.wr.addr = addr;
                     word_ctl.wr.data = w_new;
                  end else begin
                     fits_in = 1'b0;
                  end
               end else begin
                  fits_in = 1'b0;
               end
            end
            default: begin
               fits_in = fits_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         excess_ff <= '0;
         nz_ff     <= '0;
         fits_ff   <= 1'b1;
      end else begin
         excess_ff <= excess_in;
         nz_ff     <= nz_in;
         fits_ff   <= fits_in;
      end
   end

   // answer on the last letter of a word
   assign push          = s1_vld_ff && (s1_type_ff == REQ_WORD) && s1_last_ff;
   assign push_possible = fits_in && (excess_in == '0);

endmodule

// File: src/lmc_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmc_rsp_fifo: result queue
// Three-entry queue that parts the update stage from the result channel.
// ----------------------------------------------------------------------------
module lmc_rsp_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           push_data,
   input  logic                           pop,
   output logic                           not_empty,
   output logic                           head_data,
   output logic [lmc_pkg::RSP_CNT_W-1:0]  count
);
   import lmc_pkg::*;

   logic                 data_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_CNT_W-1:0] count_ff;

   // store the word's answer
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   // advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + RSP_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + RSP_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - RSP_CNT_W'(1);
         end
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_data = data_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// File: src/letter_multiset_containment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_multiset_containment: can a word be spelt from a letter pool
// Pool and word letters stream into two letter histograms; a word's last
// letter returns whether every word count stays within its pool count.
// ----------------------------------------------------------------------------
//  channel   ports                                        direction
//  req       req_valid/req_ready, req_type, req_letter,   in
//            req_first, req_last
//  rsp       rsp_valid/rsp_ready, rsp_possible            out
//
//  One letter is taken each cycle while req_ready is high. A letter's reads go
//  out on acceptance and its read-modify-write finishes the next cycle; the
//  answer enters a three-entry queue, and rsp_valid rises once it is queued.
//  Reset clears both histograms at once through per-entry valid bits.
//  req_ready drops, for any letter type, only while the queued answers and
//  the word in flight would fill the queue; with rsp_ready high it never drops.
// ----------------------------------------------------------------------------
module letter_multiset_containment #(
   parameter int MAX_POOL = lmc_pkg::MAX_POOL_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [lmc_pkg::LETTER_W-1:0]  req_letter,
   input  logic                          req_first,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_possible
);
   import lmc_pkg::*;

   logic               accept;
   hist_rd_type        rd;
   hist_ctl_type       pool_ctl;
   hist_ctl_type       word_ctl;
   logic [COUNT_W-1:0] pool_old;
   logic [COUNT_W-1:0] word_old;
   logic               push;
   logic               push_possible;
   logic [RSP_CNT_W:0] room_used;
   logic [RSP_CNT_W-1:0] rsp_count;

   // keep room for the answer of the word in flight
   assign room_used = (RSP_CNT_W + 1)'(rsp_count) + (RSP_CNT_W + 1)'(push);
   assign req_ready = (room_used < (RSP_CNT_W + 1)'(RSP_DEPTH));
   assign accept    = req_valid && req_ready;

   // issue reads to both histograms on acceptance
   assign rd.rd_en = accept && (req_letter < LETTER_W'(NUM_LETTERS));
   assign rd.addr  = req_letter[ADDR_W-1:0];

   lmc_hist u_pool_hist (
      .clock     (clock),
      .reset     (reset),
      .rd        (rd),
      .ctl       (pool_ctl),
      .old_count (pool_old)
   );

   lmc_hist u_word_hist (
      .clock     (clock),
      .reset     (reset),
      .rd        (rd),
      .ctl       (word_ctl),
      .old_count (word_old)
   );

   lmc_update #(
      .MAX_POOL (MAX_POOL)
   ) u_update (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_type      (req_type),
      .req_letter    (req_letter),
      .req_first     (req_first),
      .req_last      (req_last),
      .pool_old      (pool_old),
      .word_old      (word_old),
      .pool_ctl      (pool_ctl),
      .word_ctl      (word_ctl),
      .push          (push),
      .push_possible (push_possible)
   );

   lmc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_possible),
      .pop       (rsp_valid && rsp_ready),
      .not_empty (rsp_valid),
      .head_data (rsp_possible),
      .count     (rsp_count)
   );

endmodule
